FILE: rtl/offset_base64_frame_encoder_core_defines.svh
// assertion macros for the frame encoder
`ifndef OFFSET_BASE64_FRAME_ENCODER_CORE_DEFINES_SVH
`define OFFSET_BASE64_FRAME_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OB64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define OB64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ob64_pkg.sv
package ob64_pkg;

    localparam int NumSlots = 10;

    localparam logic [7:0] CharStart    = 8'h23;
    localparam logic [7:0] CharAddrBase = 8'h61;
    localparam logic [7:0] CharOffset   = 8'h3D;
    localparam logic [7:0] CharCr       = 8'h0D;

    localparam logic [NumSlots-1:0] SlotStart = 10'b00_0000_0001;
    localparam logic [NumSlots-1:0] SlotAddr  = 10'b00_0000_0010;
    localparam logic [NumSlots-1:0] SlotCmd   = 10'b00_0000_0100;
    localparam logic [NumSlots-1:0] SlotGrp0  = 10'b00_0000_1000;
    localparam logic [NumSlots-1:0] SlotGrp1  = 10'b00_0001_0000;
    localparam logic [NumSlots-1:0] SlotGrp2  = 10'b00_0010_0000;
    localparam logic [NumSlots-1:0] SlotGrp3  = 10'b00_0100_0000;
    localparam logic [NumSlots-1:0] SlotSumHi = 10'b00_1000_0000;
    localparam logic [NumSlots-1:0] SlotSumLo = 10'b01_0000_0000;
    localparam logic [NumSlots-1:0] SlotCr    = 10'b10_0000_0000;

    typedef struct packed {
        logic [NumSlots-1:0] mask;
        logic [7:0]          address;
        logic [7:0]          command;
        logic [7:0]          byte0;
        logic [7:0]          byte1;
        logic [7:0]          byte2;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: rtl/offset_base64_frame_encoder_core.sv
// channel   | dir | tdata                          | tuser                    | tlast
// s_axis    | in  | data_byte, command, address    | has_data, first_item     | last_item
// m_axis    | out | out_char                       | frame_end                | run_end
//
// the back end sends one character per cycle while m_axis_tready is high, and an
// item causes up to ten results (4/3 on average for plain payload bytes)
// a two-entry job queue sits between the byte packer and the character sequencer
// an item that causes no result never enters the queue
// reset clears group position, checksum, queue and output valid flag
// s_axis_tready drops only while the queue is full
`include "offset_base64_frame_encoder_core_defines.svh"

module offset_base64_frame_encoder_core
    import ob64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte, command, address
    input  logic [1:0]  s_axis_tuser,  // has_data, first_item
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_char
    output logic        m_axis_tuser,  // frame_end
    output logic        m_axis_tlast
);

    logic         accept;
    logic         push;
    logic         pop;
    logic         busy;
    job_t         push_job;
    job_t         head;
    fifo_status_t status;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !status.full;

    ob64_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata[7:0]),
        .has_data   (s_axis_tuser[0]),
        .first_item (s_axis_tuser[1]),
        .last_item  (s_axis_tlast),
        .command    (s_axis_tdata[15:8]),
        .address    (s_axis_tdata[23:16]),
        .push       (push),
        .job        (push_job)
    );

    ob64_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    ob64_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!status.empty),
        .pop        (pop),
        .busy       (busy),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (m_axis_tdata),
        .run_end    (m_axis_tlast),
        .frame_end  (m_axis_tuser)
    );

    `OB64_ASSERT_NOW(a_push_has_work, push, push_job.mask != '0, "empty job pushed")
    `OB64_ASSERT_NOW(a_frame_end_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end not last of run")
    `OB64_ASSERT_NEXT(a_idle_drains, !busy && status.empty && m_axis_tready, !m_axis_tvalid, "output without work")

endmodule

FILE: rtl/ob64_front.sv
module ob64_front
    import ob64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       has_data,
    input  logic       first_item,
    input  logic       last_item,
    input  logic [7:0] command,
    input  logic [7:0] address,
    output logic       push,
    output job_t       job
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] held1_reg;
    logic [7:0] held1_next;
    logic [7:0] held2_reg;
    logic [7:0] held2_next;
    logic [1:0] pos_start;
    logic [1:0] pos_mid;
    logic       grp;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;

    always_comb
    begin
        pos_start  = first_item ? 2'd0 : pos_reg;
        pos_mid    = pos_start;
        held1_next = held1_reg;
        held2_next = held2_reg;
        grp        = 1'b0;
        b0         = held1_reg;
        b1         = held2_reg;
        b2         = data_byte;
        if (has_data)
        begin
            case (pos_start)
                2'd0:
                begin
                    held1_next = data_byte;
                    pos_mid    = 2'd1;
                end
                2'd1:
                begin
                    held2_next = data_byte;
                    pos_mid    = 2'd2;
                end
                default:
                begin
                    grp     = 1'b1;
                    pos_mid = 2'd0;
                end
            endcase
        end
        pos_next = pos_mid;
        if (last_item)
        begin
            pos_next = 2'd0;
            if (pos_mid != 2'd0)
            begin
                grp = 1'b1;
                b0  = held1_next;
                b1  = (pos_mid == 2'd1) ? 8'h00 : held2_next;
                b2  = 8'h00;
            end
        end
    end

    assign job.mask    = {{3{last_item}}, {4{grp}}, {3{first_item}}};
    assign job.address = address;
    assign job.command = command;
    assign job.byte0   = b0;
    assign job.byte1   = b1;
    assign job.byte2   = b2;
    assign push        = accept && (job.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            held1_reg <= 8'h00;
            held2_reg <= 8'h00;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            held1_reg <= held1_next;
            held2_reg <= held2_next;
        end
    end

endmodule

FILE: rtl/ob64_fifo.sv
module ob64_fifo
    import ob64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  job_t         push_job,
    input  logic         pop,
    output job_t         head,
    output fifo_status_t status
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/ob64_back.sv
module ob64_back
    import ob64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       run_end,
    output logic       frame_end
);

    job_t                job_reg;
    logic [NumSlots-1:0] mask_reg;
    logic [NumSlots-1:0] mask_next;
    logic [NumSlots-1:0] lowest;
    logic [NumSlots-1:0] remain;
    logic [11:0]         sum_reg;
    logic [11:0]         sum_next;
    logic                valid_reg;
    logic [7:0]          char_reg;
    logic                run_end_reg;
    logic                frame_end_reg;
    logic                load;
    logic                emit;
    logic [7:0]          ch;
    logic [5:0]          six;

    assign load   = !valid_reg || out_ready;
    assign emit   = load && (mask_reg != '0);
    assign lowest = mask_reg & (~mask_reg + {{(NumSlots-1){1'b0}}, 1'b1});
    assign remain = mask_reg & ~lowest;
    assign pop    = head_valid && ((mask_reg == '0) || (emit && (remain == '0)));
    assign busy   = (mask_reg != '0);

    always_comb
    begin
        six      = 6'd0;
        ch       = CharCr;
        sum_next = sum_reg;
        case (lowest)
            SlotStart:
            begin
                ch       = CharStart;
                sum_next = {4'h0, CharStart};
            end
            SlotAddr:
            begin
                ch       = CharAddrBase + job_reg.address;
                sum_next = sum_reg + {4'h0, ch};
            end
            SlotCmd:
            begin
                ch       = job_reg.command;
                sum_next = sum_reg + {4'h0, ch};
            end
            SlotGrp0:
            begin
                six      = job_reg.byte0[7:2];
                ch       = CharOffset + {2'b00, six};
                sum_next = sum_reg + {4'h0, ch};
            end
            SlotGrp1:
            begin
                six      = {job_reg.byte0[1:0], job_reg.byte1[7:4]};
                ch       = CharOffset + {2'b00, six};
                sum_next = sum_reg + {4'h0, ch};
            end
            SlotGrp2:
            begin
                six      = {job_reg.byte1[3:0], job_reg.byte2[7:6]};
                ch       = CharOffset + {2'b00, six};
                sum_next = sum_reg + {4'h0, ch};
            end
            SlotGrp3:
            begin
                six      = job_reg.byte2[5:0];
                ch       = CharOffset + {2'b00, six};
                sum_next = sum_reg + {4'h0, ch};
            end
            SlotSumHi:
            begin
                ch = CharOffset + {2'b00, sum_reg[11:6]};
            end
            SlotSumLo:
            begin
                ch = CharOffset + {2'b00, sum_reg[5:0]};
            end
            SlotCr:
            begin
                ch       = CharCr;
                sum_next = 12'h000;
            end
            default:
            begin
                ch       = CharCr;
                sum_next = sum_reg;
            end
        endcase
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (emit)
        begin
            mask_next = remain;
        end
        if (pop)
        begin
            mask_next = head.mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (emit)
        begin
            char_reg      <= ch;
            run_end_reg   <= (remain == '0);
            frame_end_reg <= (lowest == SlotCr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            sum_reg   <= 12'h000;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
            begin
                sum_reg <= sum_next;
            end
            if (load)
            begin
                valid_reg <= emit;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign run_end   = run_end_reg;
    assign frame_end = frame_end_reg;

endmodule
